// ===== sv/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package fpba_pkg;

    // Default sizing of the free-size table.
    localparam int NBLOCKS_DEF   = 16;
    localparam int SIZE_BITS_DEF = 16;

    // Fixed field widths of the channels and the configuration port.
    localparam int FUNC_W     = 1;
    localparam int SLOT_W     = 4;
    localparam int SIZE_W     = 16;
    localparam int INDEX_W    = 4;
    localparam int REMAIN_W   = 16;
    localparam int POLICY_W   = 2;
    localparam int BIU_W      = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // Item kinds.
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b1;

    // Placement policies; the unused code behaves as first fit.
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [POLICY_W-1:0] POLICY_RESET = POLICY_FIRST;
    localparam logic [BIU_W-1:0]    BIU_RESET    = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;    // write a load item into the table
        logic req_start;  // capture a request and clear the search state
        logic scan_rd;    // read the slot under the scan counter
        logic cmp;        // compare the slot read in the previous cycle
        logic wb;         // write back the chosen slot and load the result
    } fpba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic limit_zero; // no slots are searched
        logic scan_last;  // scan counter is on the last searched slot
        logic out_free;   // result register can take a new result
    } fpba_status_t;

endpackage

// ===== sv/fpba_if.sv =====
// Valid/ready channel interfaces for allocator items and results.
// Depends on fpba_pkg for the field widths.
interface fpba_in_if
    import fpba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] block_slot;
    logic [SIZE_W-1:0] size;

    modport source (output valid, output func, output block_slot, output size, input ready);
    modport sink   (input valid, input func, input block_slot, input size, output ready);
endinterface

interface fpba_out_if
    import fpba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                granted;
    logic [INDEX_W-1:0]  block_index;
    logic [REMAIN_W-1:0] remaining;

    modport source (output valid, output granted, output block_index, output remaining,
                    input ready);
    modport sink   (input valid, input granted, input block_index, input remaining,
                    output ready);
endinterface

// ===== sv/fpba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/fpba_ctrl.sv =====
// Controller state machine of the allocator: sequences loads, the slot scan,
// and the write-back of a request. Depends on fpba_pkg.
module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [FUNC_W-1:0] item_func,
    input  fpba_status_t      status,
    output logic              item_ready,
    output fpba_cmd_t         cmd
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WB
    } state_t;

    state_t state_reg, state_next;
    logic   cmp_reg, cmp_next;

    always_comb
    begin
        state_next    = state_reg;
        cmp_next      = 1'b0;
        item_ready    = 1'b0;
        cmd           = '0;
        cmd.cmp       = cmp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_func == FUNC_REQUEST)
                    begin
                        cmd.req_start = 1'b1;
                        state_next    = status.limit_zero ? ST_WB : ST_SCAN;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                cmp_next    = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (status.out_free)
                begin
                    cmd.wb     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmp_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmp_reg   <= cmp_next;
        end
    end
endmodule

// ===== sv/fpba_dp.sv =====
// Datapath of the allocator: configuration registers, free-size table with
// valid bits, scan counter, selection compare and result register.
// Depends on fpba_pkg and fpba_ram.
module fpba_dp
    import fpba_pkg::*;
#(
    parameter int NBLOCKS   = NBLOCKS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SLOT_W-1:0]     item_slot,
    input  logic [SIZE_W-1:0]     item_size,
    input  fpba_cmd_t             cmd,
    output fpba_status_t          status,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  res_granted,
    output logic [INDEX_W-1:0]    res_index,
    output logic [REMAIN_W-1:0]   res_remaining
);
    localparam int AW = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
    localparam int CW = $clog2(NBLOCKS + 1);

    logic [POLICY_W-1:0]  policy_reg;
    logic [BIU_W-1:0]     biu_reg;
    logic [NBLOCKS-1:0]   valid_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 found_reg;
    logic                 out_valid_reg;
    logic [SIZE_BITS-1:0] amount_reg;
    logic [AW-1:0]        idx_d_reg;
    logic                 valid_d_reg;
    logic [AW-1:0]        pick_reg;
    logic [SIZE_BITS-1:0] pick_val_reg;
    logic                 out_granted_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic [REMAIN_W-1:0]  out_remain_reg;

    logic [CW-1:0]        limit;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        load_addr;
    logic                 load_ok;
    logic [SIZE_BITS-1:0] rd_data;
    logic [SIZE_BITS-1:0] cur_val;
    logic                 take;
    logic [SIZE_BITS-1:0] new_val;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;

    // Searched slot count, clipped to the table size.
    assign limit = (32'(biu_reg) > NBLOCKS) ? CW'(NBLOCKS) : CW'(biu_reg);

    assign rd_addr   = cnt_reg[AW-1:0];
    assign load_addr = AW'(item_slot);
    assign load_ok   = (32'(item_slot) < NBLOCKS);

    // A slot never loaded since reset reads as zero.
    assign cur_val = valid_d_reg ? rd_data : '0;

    // First fit keeps the first hit; best and worst fit replace on a strict win,
    // so ties stay with the lower index.
    always_comb
    begin
        take = 1'b0;
        if (cur_val >= amount_reg)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (policy_reg == POLICY_BEST)
            begin
                take = (cur_val < pick_val_reg);
            end
            else if (policy_reg == POLICY_WORST)
            begin
                take = (cur_val > pick_val_reg);
            end
        end
    end

    assign new_val = pick_val_reg - amount_reg;

    assign ram_we    = (cmd.load_wr && load_ok) || (cmd.wb && found_reg);
    assign ram_waddr = cmd.wb ? pick_reg : load_addr;
    assign ram_wdata = cmd.wb ? new_val : SIZE_BITS'(item_size);

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NBLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_rd),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POLICY_RESET;
            biu_reg       <= BIU_RESET;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_POLICY: policy_reg <= cfg_data[POLICY_W-1:0];
                    CFG_BLOCKS: biu_reg    <= cfg_data[BIU_W-1:0];
                    default:    ;
                endcase
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.req_start)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_rd)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.cmp && take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.wb)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_start)
        begin
            amount_reg <= SIZE_BITS'(item_size);
        end
        if (cmd.scan_rd)
        begin
            idx_d_reg   <= rd_addr;
            valid_d_reg <= valid_reg[rd_addr];
        end
        if (cmd.cmp && take)
        begin
            pick_reg     <= idx_d_reg;
            pick_val_reg <= cur_val;
        end
        if (cmd.wb)
        begin
            out_granted_reg <= found_reg;
            out_index_reg   <= found_reg ? INDEX_W'(pick_reg) : '0;
            out_remain_reg  <= found_reg ? REMAIN_W'(new_val) : '0;
        end
    end

    assign status.limit_zero = (limit == '0);
    assign status.scan_last  = ((cnt_reg + CW'(1)) == limit);
    assign status.out_free   = !out_valid_reg || res_ready;

    assign res_valid     = out_valid_reg;
    assign res_granted   = out_granted_reg;
    assign res_index     = out_index_reg;
    assign res_remaining = out_remain_reg;
endmodule

// ===== sv/fit_policy_block_allocator.sv =====
// Fit-policy block allocator (first, best or worst fit); uses fpba_pkg, fpba_if, fpba_ram,
// fpba_ctrl and fpba_dp. Loads may follow every cycle while the controller is idle; a
// request scans N = min(blocks_in_use, NBLOCKS) slots, one slot per cycle through the
// table's single read port, and no new item is taken until its result is registered.
// Reset clears the valid bits so every slot reads as zero, and sets first fit and 16 slots.
module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int NBLOCKS   = NBLOCKS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fpba_in_if.sink               item,
    fpba_out_if.source            result
);
    // The controller and the datapath talk only through these two groups.
    fpba_cmd_t    cmd;
    fpba_status_t status;

    // The controller takes a new item only when it is idle. A load is written into
    // the table at the edge of its transfer. A request, unless no slot is searched, starts a
    // scan from slot zero: one slot address is issued per cycle, and the registered read data
    // is compared in the next cycle against the request and the current pick.
    fpba_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_func  (item.func),
        .status     (status),
        .item_ready (item.ready),
        .cmd        (cmd)
    );

    // The datapath holds the configuration, the table, and the result register. The
    // result register stands between the scan and the result channel, so the next
    // item is accepted while a finished result still waits; a request that reaches
    // write-back while the register is still full holds until the result transfer.
    fpba_dp #(
        .NBLOCKS   (NBLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .item_slot     (item.block_slot),
        .item_size     (item.size),
        .cmd           (cmd),
        .status        (status),
        .res_valid     (result.valid),
        .res_ready     (result.ready),
        .res_granted   (result.granted),
        .res_index     (result.block_index),
        .res_remaining (result.remaining)
    );
endmodule
